// ===== rtl/wrps_pkg.sv =====
package wrps_pkg;

   // default number of next hop entries
   localparam int MAX_HOPS_DEF = 8;

   // item kinds
   localparam logic [1:0] KIND_SELECT   = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_CLEAR    = 2'd2;

   // field and state widths
   localparam int ACT_W  = 4;
   localparam int RND_W  = 16;
   localparam int SEL_W  = 3;
   localparam int PEND_W = 16;
   localparam int AVG_W  = 32;
   localparam int WGT_W  = 20;

   // averaging coefficients, Q0.16
   localparam logic [15:0] ALPHA_Q16 = 16'd58982;
   localparam logic [15:0] BETA_Q16  = 16'd6554;
   localparam logic [15:0] ROUND_Q16 = 16'd32768;

   // average floor and weight limits
   localparam logic [AVG_W-1:0]  AVG_THRESH = 32'd66;
   localparam logic [AVG_W-1:0]  AVG_MIN    = 32'd6554;
   localparam logic [WGT_W-1:0]  WGT_ONE    = 20'h10000;
   localparam logic [WGT_W-1:0]  WGT_MAX    = 20'hFFFFF;
   localparam logic [PEND_W-1:0] PEND_MAX   = 16'hFFFF;

   // reciprocal 2^32 / avg: the average is never below 66, so dividend
   // bits 32..26 give a zero quotient and leave a partial remainder of 64
   localparam int              DIV_STEPS    = 26;
   localparam logic [AVG_W-1:0] DIV_REM_INIT = 32'd64;

   typedef struct packed {
      logic [1:0]       kind;
      logic [2:0]       hop_index;
      logic [RND_W-1:0] random_value;
   } req_word_type;

   typedef struct packed {
      logic [SEL_W-1:0] selected_hop;
      logic             selected_valid;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic clear_all;
      logic pick_req;
      logic sum_step;
      logic point_mul;
      logic walk_step;
      logic pend_upd;
      logic avg_mul;
      logic avg_add;
      logic div_start;
      logic commit;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       none_live;
      logic       hop_ok;
      logic       idx_last;
      logic       walk_hit;
      logic       div_busy;
   } dp_status_type;

endpackage

// ===== rtl/wrps_div.sv =====
module wrps_div import wrps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [AVG_W-1:0]     divisor,
   output logic                 busy,
   output logic [DIV_STEPS-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_STEPS + 1);

   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [AVG_W-1:0]     rem_ff, rem_in;
   logic [AVG_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_STEPS-1:0] q_ff, q_in;
   logic [AVG_W:0]       shifted;

   assign shifted  = {rem_ff, 1'b0};
   assign busy     = (cnt_ff != '0);
   assign quotient = q_ff;

   // one restoring step per cycle, low dividend bits are all zero
   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      q_in   = q_ff;
      if (start) begin
         cnt_in = CNT_W'(DIV_STEPS);
         rem_in = DIV_REM_INIT;
         dvs_in = divisor;
         q_in   = '0;
      end else if (busy) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = AVG_W'(shifted - {1'b0, dvs_ff});
            q_in   = {q_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_in = shifted[AVG_W-1:0];
            q_in   = {q_ff[DIV_STEPS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
   end

endmodule

// ===== rtl/wrps_datapath.sv =====
module wrps_datapath import wrps_pkg::*; #(
   parameter int MAX_HOPS = MAX_HOPS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [ACT_W-1:0] csr_wdata,
   input  req_word_type  req_word,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   output rsp_word_type  rsp_word
);

   localparam int IDX_W = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
   localparam int CNT_W = $clog2(MAX_HOPS + 1);
   localparam int SUM_W = WGT_W + $clog2(MAX_HOPS);
   localparam int PT_W  = RND_W + SUM_W;
   localparam int PA_W  = AVG_W + 16;
   localparam int PP_W  = PEND_W + 16;

   logic [ACT_W-1:0]  active_ff, active_in;
   req_word_type      req_ff, req_in;
   logic [CNT_W-1:0]  live_ff, live_in, live_calc;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  sel_ff, sel_in;
   logic              sel_valid_ff, sel_valid_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  run_ff, run_in;
   logic [PT_W-1:0]   point_ff, point_in;
   logic [PA_W-1:0]   prod_a_ff, prod_a_in;
   logic [PP_W-1:0]   prod_p_ff, prod_p_in;
   logic [AVG_W-1:0]  avg_new_ff, avg_new_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_ff, rsp_in;

   logic [PEND_W-1:0] pend_ff [MAX_HOPS];
   logic [PEND_W-1:0] pend_in [MAX_HOPS];
   logic [AVG_W-1:0]  avg_ff  [MAX_HOPS];
   logic [AVG_W-1:0]  avg_in  [MAX_HOPS];
   logic [WGT_W-1:0]  wgt_ff  [MAX_HOPS];
   logic [WGT_W-1:0]  wgt_in  [MAX_HOPS];

   logic [WGT_W-1:0]     wgt_rd;
   logic [PEND_W-1:0]    pend_rd;
   logic [AVG_W-1:0]     avg_rd;
   logic [SUM_W-1:0]     sum_add, run_add;
   logic                 walk_hit, idx_last;
   logic [AVG_W:0]       avg_sum;
   logic [AVG_W-1:0]     avg_sat, avg_fix;
   logic                 div_busy;
   logic [DIV_STEPS-1:0] div_q;
   logic [WGT_W-1:0]     wgt_new;

   // reciprocal unit for the weight
   wrps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (avg_new_ff),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // clamp the active count to the table size
   always_comb begin
      if (32'(active_ff) > MAX_HOPS) begin
         live_calc = CNT_W'(MAX_HOPS);
      end else begin
         live_calc = CNT_W'(active_ff);
      end
   end

   // table reads: weight at the walk index, pending and average at the chosen hop
   assign wgt_rd  = wgt_ff[idx_ff];
   assign pend_rd = pend_ff[sel_ff];
   assign avg_rd  = avg_ff[sel_ff];

   assign sum_add  = sum_ff + SUM_W'(wgt_rd);
   assign run_add  = run_ff + SUM_W'(wgt_rd);
   assign walk_hit = (point_ff < {run_add, 16'h0000});
   assign idx_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == live_ff);

   // finish the average: add, saturate, floor
   assign avg_sum = {1'b0, prod_a_ff[PA_W-1:16]} + (AVG_W+1)'(prod_p_ff);
   assign avg_sat = avg_sum[AVG_W] ? '1 : avg_sum[AVG_W-1:0];
   assign avg_fix = (avg_sat < AVG_THRESH) ? AVG_MIN : avg_sat;

   // saturate the reciprocal into the weight
   assign wgt_new = (div_q > DIV_STEPS'(WGT_MAX)) ? WGT_MAX : div_q[WGT_W-1:0];

   always_comb begin
      active_in    = active_ff;
      req_in       = req_ff;
      live_in      = live_ff;
      idx_in       = idx_ff;
      sel_in       = sel_ff;
      sel_valid_in = sel_valid_ff;
      sum_in       = sum_ff;
      run_in       = run_ff;
      point_in     = point_ff;
      prod_a_in    = prod_a_ff;
      prod_p_in    = prod_p_ff;
      avg_new_in   = avg_new_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pend_in      = pend_ff;
      avg_in       = avg_ff;
      wgt_in       = wgt_ff;

      if (csr_we) begin
         active_in = csr_wdata;
      end

      // latch the word and start a fresh walk
      if (cmd.load) begin
         req_in       = req_word;
         live_in      = live_calc;
         idx_in       = '0;
         sel_in       = '0;
         sel_valid_in = 1'b0;
         sum_in       = '0;
         run_in       = '0;
      end

      if (cmd.pick_req) begin
         sel_in = IDX_W'(req_ff.hop_index);
      end

      // accumulate the total weight
      if (cmd.sum_step) begin
         sum_in = sum_add;
         idx_in = idx_last ? '0 : idx_ff + IDX_W'(1);
      end

      if (cmd.point_mul) begin
         point_in = PT_W'(req_ff.random_value) * PT_W'(sum_ff);
      end

      // walk until the running weight passes the point
      if (cmd.walk_step) begin
         run_in = run_add;
         if (walk_hit) begin
            sel_in       = idx_ff;
            sel_valid_in = 1'b1;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end

      // bump or drop the pending count, saturating both ways
      if (cmd.pend_upd) begin
         if (req_ff.kind == KIND_SELECT) begin
            if (pend_rd != PEND_MAX) begin
               pend_in[sel_ff] = pend_rd + PEND_W'(1);
            end
         end else begin
            if (pend_rd != '0) begin
               pend_in[sel_ff] = pend_rd - PEND_W'(1);
            end
         end
      end

      if (cmd.avg_mul) begin
         prod_a_in = PA_W'(avg_rd) * PA_W'(ALPHA_Q16) + PA_W'(ROUND_Q16);
         prod_p_in = PP_W'(pend_rd) * PP_W'(BETA_Q16);
      end

      if (cmd.avg_add) begin
         avg_new_in = avg_fix;
      end

      if (cmd.commit) begin
         avg_in[sel_ff] = avg_new_ff;
         wgt_in[sel_ff] = wgt_new;
      end

      // restore every hop entry
      if (cmd.clear_all) begin
         for (int i = 0; i < MAX_HOPS; i++) begin
            pend_in[i] = '0;
            avg_in[i]  = '0;
            wgt_in[i]  = WGT_ONE;
         end
      end

      if (cmd.finish) begin
         rsp_valid_in          = 1'b1;
         rsp_in.selected_valid = sel_valid_ff;
         rsp_in.selected_hop   = sel_valid_ff ? SEL_W'(sel_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_HOPS; i++) begin
            pend_ff[i] <= '0;
            avg_ff[i]  <= '0;
            wgt_ff[i]  <= WGT_ONE;
         end
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         avg_ff       <= avg_in;
         wgt_ff       <= wgt_in;
      end
      req_ff       <= req_in;
      live_ff      <= live_in;
      idx_ff       <= idx_in;
      sel_ff       <= sel_in;
      sel_valid_ff <= sel_valid_in;
      sum_ff       <= sum_in;
      run_ff       <= run_in;
      point_ff     <= point_in;
      prod_a_ff    <= prod_a_in;
      prod_p_ff    <= prod_p_in;
      avg_new_ff   <= avg_new_in;
      rsp_ff       <= rsp_in;
   end

   assign status.kind      = req_ff.kind;
   assign status.none_live = (live_ff == '0);
   assign status.hop_ok    = (32'(req_ff.hop_index) < 32'(live_ff));
   assign status.idx_last  = idx_last;
   assign status.walk_hit  = walk_hit;
   assign status.div_busy  = div_busy;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTHESIS
   // the last live hop always closes the walk
   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step && idx_last |-> walk_hit)
      else $error("walk passed the last live hop without a hit");

   // a weight written back is never zero
   a_wgt_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> div_q != '0)
      else $error("zero reciprocal at commit");

   // the new average respects the floor
   a_avg_floor: assert property (@(posedge clock) disable iff (reset)
      cmd.avg_add |=> avg_new_ff >= AVG_THRESH)
      else $error("average below floor");

   // only a select request reports a hop
   a_sel_kind: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && sel_valid_ff |-> req_ff.kind == KIND_SELECT)
      else $error("hop reported for a non-select word");
`endif

endmodule

// ===== rtl/wrps_ctrl.sv =====
module wrps_ctrl import wrps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DECODE = 4'd1;
   localparam logic [3:0] ST_SUM    = 4'd2;
   localparam logic [3:0] ST_POINT  = 4'd3;
   localparam logic [3:0] ST_WALK   = 4'd4;
   localparam logic [3:0] ST_PEND   = 4'd5;
   localparam logic [3:0] ST_AVGM   = 4'd6;
   localparam logic [3:0] ST_AVGA   = 4'd7;
   localparam logic [3:0] ST_DIVS   = 4'd8;
   localparam logic [3:0] ST_DIVW   = 4'd9;
   localparam logic [3:0] ST_DONE   = 4'd10;

   logic [3:0] state_ff, state_in;

   assign busy = (state_ff != ST_IDLE);

   // sequence one word through the datapath
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (status.kind == KIND_SELECT) begin
               state_in = status.none_live ? ST_DONE : ST_SUM;
            end else if (status.kind == KIND_COMPLETE) begin
               cmd.pick_req = status.hop_ok;
               state_in     = status.hop_ok ? ST_PEND : ST_DONE;
            end else if (status.kind == KIND_CLEAR) begin
               cmd.clear_all = 1'b1;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (status.idx_last) begin
               state_in = ST_POINT;
            end
         end
         ST_POINT: begin
            cmd.point_mul = 1'b1;
            state_in      = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_hit) begin
               state_in = ST_PEND;
            end
         end
         ST_PEND: begin
            cmd.pend_upd = 1'b1;
            state_in     = ST_AVGM;
         end
         ST_AVGM: begin
            cmd.avg_mul = 1'b1;
            state_in    = ST_AVGA;
         end
         ST_AVGA: begin
            cmd.avg_add = 1'b1;
            state_in    = ST_DIVS;
         end
         ST_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVW;
         end
         ST_DIVW: begin
            if (!status.div_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/weighted_random_path_selector_top.sv =====
// One word at a time: busy stays high until the result strobe while the controller runs
//   the hop weight walks and the 26-step bit-serial reciprocal unit. The receiver cannot stall.
// Synchronous reset clears the active hop count, all hop entries (weight 1.0)
//   and the controller; the next word is accepted the cycle after reset drops.
module weighted_random_path_selector_top import wrps_pkg::*; #(
   parameter int MAX_HOPS = MAX_HOPS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_word_type     req_word,
   output logic             rsp_valid,
   output rsp_word_type     rsp_word,
   input  logic             csr_we,
   input  logic [ACT_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          start_ok;

   // take a word only while idle
   assign start_ok = start && !busy;

   wrps_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ok),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   wrps_datapath #(
      .MAX_HOPS (MAX_HOPS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule
